### src/wpac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpac_pkg: shared constants, types and helpers
// Sizes, command codes and register map of the waveform persistence engine.
// ----------------------------------------------------------------------------
package wpac_pkg;

    // Store geometry
    localparam int MAX_COLUMNS = 2048;
    localparam int LEVELS      = 256;
    localparam int MAX_VSCALE  = 8;
    localparam int STORE_DEPTH = MAX_COLUMNS * LEVELS;
    localparam int LANES       = 8;                      // counters per memory row
    localparam int LANE_W      = $clog2(LANES);
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int ROW_W       = IDX_W - LANE_W;
    localparam int ROWS        = STORE_DEPTH / LANES;

    // Field widths
    localparam int CNT_W  = 8;
    localparam int COL_W  = 11;
    localparam int LVL_W  = 8;
    localparam int CMD_W  = 2;
    localparam int GAIN_W = 16;
    localparam int VSC_W  = 4;
    localparam int WID_W  = 12;
    localparam int OFS_W  = 22;
    localparam int RGBA_W = 32;
    localparam int PROD_W = GAIN_W + CNT_W;
    localparam int VS_W   = $clog2(MAX_VSCALE + 1);
    localparam int LV_W   = LVL_W + VS_W;

    // Stream words
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;
    localparam int S_PAD_W   = S_TDATA_W - COL_W - LVL_W;
    localparam int M_PAD_W   = M_TDATA_W - OFS_W - RGBA_W;

    // Register port
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_RED    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GREEN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BLUE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VSCALE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd4;

    localparam logic [VSC_W-1:0] VSCALE_RST = 4'd1;
    localparam logic [WID_W-1:0] WIDTH_RST  = 12'd2048;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] CHAN_MAX     = 8'hff;

    typedef logic [CNT_W*LANES-1:0] t_row;

    // (gain * count) >> 8, saturated to 255
    function automatic logic [7:0] sat_channel(input logic [PROD_W-1:0] prod);
        logic [7:0] res;
        if (|prod[PROD_W-1:16]) begin
            res = CHAN_MAX;
        end else begin
            res = prod[15:8];
        end
        return res;
    endfunction

endpackage

### src/waveform_persistence_accumulate_colorize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_persistence_accumulate_colorize: persistence histogram engine
// Per-(column, level) 8-bit hit counters in one synchronous RAM, with
// accumulate, colorizing read-out over vertical_scale rows, and clear.
// ----------------------------------------------------------------------------
// Usage notes. Each input word carries a command in tuser and a sample
// (column, level) in tdata. Accumulate adds one hit to the cell and gives no
// output; it is pipelined read-modify-write over a read and a write RAM port,
// so one word is taken every clock, back-to-back hits on the same RAM row are
// forwarded from the write stage. The RAM holds 8 counters per row (65536
// rows x 64 bits). A read command emits N words before the next word is
// accepted, where N is the clamped vertical scale (1..8), or one word for an
// empty cell; the N output words stream at one per clock while the output
// side is ready, and the output register lets a finished word wait without
// blocking the state machine's last step. A clear command, and the state
// after reset, runs a clearing pass over all 65536 RAM rows, one per cycle,
// during which no input word is accepted; register writes are taken at any time.
// Registers are meant to be changed only while the engine is idle.
// ----------------------------------------------------------------------------
module waveform_persistence_accumulate_colorize (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Sample/command input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [10:0] column, [18:11] level, [23:19] zero
    input  logic [wpac_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [wpac_pkg::CMD_W-1:0]    s_axis_tuser,

    // Pixel output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [21:0] pixel_offset, [53:22] pixel_rgba, [55:54] zero
    output logic [wpac_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] write_enable
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,

    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wpac_pkg::APB_AW-1:0]   paddr,
    input  logic [wpac_pkg::APB_DW-1:0]   pwdata,
    output logic [wpac_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import wpac_pkg::*;

    // Control states
    localparam logic [1:0] S_IDLE = 2'd0;   // accepting words
    localparam logic [1:0] S_CNT  = 2'd1;   // read data back, multiply
    localparam logic [1:0] S_EMIT = 2'd2;   // stream out rows
    localparam logic [1:0] S_CLR  = 2'd3;   // clearing pass

    // ---------------- registers ----------------
    logic [GAIN_W-1:0] r_color_red, r_color_green, r_color_blue;
    logic [VSC_W-1:0]  r_vscale;
    logic [WID_W-1:0]  r_width;

    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_we;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_idx)
            REG_RED:    prdata = APB_DW'(r_color_red);
            REG_GREEN:  prdata = APB_DW'(r_color_green);
            REG_BLUE:   prdata = APB_DW'(r_color_blue);
            REG_VSCALE: prdata = APB_DW'(r_vscale);
            REG_WIDTH:  prdata = APB_DW'(r_width);
            default:    prdata = '0;
        endcase
    end

    // ---------------- input decode ----------------
    logic [CMD_W-1:0] in_cmd;
    logic [COL_W-1:0] in_col;
    logic [LVL_W-1:0] in_lvl;
    logic             in_acc;
    logic             col_ok;
    logic [31:0]      idx_full;
    logic [ROW_W-1:0] rd_row;
    logic [VS_W-1:0]  vs_eff;

    assign in_cmd   = s_axis_tuser;
    assign in_col   = s_axis_tdata[COL_W-1:0];
    assign in_lvl   = s_axis_tdata[COL_W +: LVL_W];
    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign col_ok   = 32'(in_col) < MAX_COLUMNS;
    assign idx_full = 32'(in_col) * LEVELS + 32'(in_lvl);
    assign rd_row   = idx_full[IDX_W-1:LANE_W];

    // scale 0 acts as 1, above the maximum acts as the maximum
    always_comb begin
        if (r_vscale == '0) begin
            vs_eff = VS_W'(1);
        end else if (32'(r_vscale) > MAX_VSCALE) begin
            vs_eff = VS_W'(MAX_VSCALE);
        end else begin
            vs_eff = VS_W'(r_vscale);
        end
    end

    // ---------------- state ----------------
    logic [1:0]        r_state;
    logic [ROW_W-1:0]  r_clr_row;
    logic              r_s1_acc;        // accumulate waiting for write-back
    logic [ROW_W-1:0]  r_s1_row;
    logic [LANE_W-1:0] r_s1_lane;
    logic              r_s1_ok;
    logic [COL_W-1:0]  r_col;
    logic [LV_W-1:0]   r_lv;            // level * scale
    logic [VS_W-1:0]   r_vs;
    logic [VS_W-1:0]   r_row;
    logic [OFS_W-1:0]  r_acc;           // (level*scale + row) * width
    logic              r_zero;
    logic [PROD_W-1:0] r_pr_red, r_pr_green, r_pr_blue;
    logic              r_fwd_valid;
    logic [ROW_W-1:0]  r_fwd_row;
    t_row              r_fwd_data;
    t_row              r_rd_data;

    logic              r_m_valid;
    logic [OFS_W-1:0]  r_m_offset;
    logic [RGBA_W-1:0] r_m_rgba;
    logic              r_m_we;
    logic              r_m_last;

    // ---------------- hit counter RAM ----------------
    t_row r_hits [ROWS];

    logic             mem_we;
    logic [ROW_W-1:0] mem_waddr;
    t_row             mem_wdata;
    t_row             row_cur;
    t_row             row_upd;
    logic [CNT_W-1:0] cnt_cur;
    logic             acc_we;
    logic             clr_we;

    // the write at the previous edge is not yet visible in the read data
    assign row_cur = (r_fwd_valid && (r_fwd_row == r_s1_row)) ? r_fwd_data : r_rd_data;
    assign cnt_cur = r_s1_ok ? row_cur[r_s1_lane*CNT_W +: CNT_W] : '0;

    always_comb begin
        row_upd = row_cur;
        row_upd[r_s1_lane*CNT_W +: CNT_W] = row_cur[r_s1_lane*CNT_W +: CNT_W] + CNT_W'(1);
    end

    assign acc_we    = r_s1_acc;
    assign clr_we    = (r_state == S_CLR);
    assign mem_we    = acc_we | clr_we;
    assign mem_waddr = clr_we ? r_clr_row : r_s1_row;
    assign mem_wdata = clr_we ? '0 : row_upd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hits[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_hits[rd_row];
    end

    // ---------------- output formatting ----------------
    logic              m_load;
    logic              row_last;
    logic [RGBA_W-1:0] rgba;

    assign m_load   = (r_state == S_EMIT) && (!r_m_valid || m_axis_tready);
    assign row_last = r_zero || (r_row == r_vs - VS_W'(1));
    assign rgba     = {ALPHA_OPAQUE, sat_channel(r_pr_blue), sat_channel(r_pr_green),
                       sat_channel(r_pr_red)};

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, r_m_rgba, r_m_offset};
    assign m_axis_tuser  = r_m_we;
    assign m_axis_tlast  = r_m_last;

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_red   <= '0;
            r_color_green <= '0;
            r_color_blue  <= '0;
            r_vscale      <= VSCALE_RST;
            r_width       <= WIDTH_RST;
            r_state       <= S_CLR;
            r_clr_row     <= '0;
            r_s1_acc      <= 1'b0;
            r_fwd_valid   <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_RED:    r_color_red   <= pwdata[GAIN_W-1:0];
                    REG_GREEN:  r_color_green <= pwdata[GAIN_W-1:0];
                    REG_BLUE:   r_color_blue  <= pwdata[GAIN_W-1:0];
                    REG_VSCALE: r_vscale      <= pwdata[VSC_W-1:0];
                    REG_WIDTH:  r_width       <= pwdata[WID_W-1:0];
                    default:    ;
                endcase
            end

            r_s1_acc    <= in_acc && (in_cmd == CMD_ACCUM) && col_ok;
            r_fwd_valid <= acc_we;

            if (m_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && in_cmd == CMD_READ) begin
                        r_state <= S_CNT;
                    end else if (in_acc && in_cmd == CMD_CLEAR) begin
                        r_state   <= S_CLR;
                        r_clr_row <= '0;
                    end
                end
                S_CNT: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (m_load && row_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLR: begin
                    r_clr_row <= r_clr_row + ROW_W'(1);
                    if (r_clr_row == ROW_W'(ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row  <= rd_row;
            r_s1_lane <= idx_full[LANE_W-1:0];
            r_s1_ok   <= col_ok;
            r_col     <= in_col;
            r_lv      <= LV_W'(in_lvl) * LV_W'(vs_eff);
            r_vs      <= vs_eff;
        end

        if (acc_we) begin
            r_fwd_row  <= r_s1_row;
            r_fwd_data <= row_upd;
        end

        if (r_state == S_CNT) begin
            r_zero     <= (cnt_cur == '0);
            r_pr_red   <= PROD_W'(r_color_red) * PROD_W'(cnt_cur);
            r_pr_green <= PROD_W'(r_color_green) * PROD_W'(cnt_cur);
            r_pr_blue  <= PROD_W'(r_color_blue) * PROD_W'(cnt_cur);
            r_acc      <= OFS_W'(24'(r_lv) * 24'(r_width));
            r_row      <= '0;
        end else if (m_load) begin
            r_acc <= r_acc + OFS_W'(r_width);
            r_row <= r_row + VS_W'(1);
        end

        if (m_load) begin
            r_m_offset <= OFS_W'(r_col) + r_acc;
            r_m_rgba   <= r_zero ? '0 : rgba;
            r_m_we     <= !r_zero;
            r_m_last   <= row_last;
        end
    end

    // ---------------- assertions ----------------
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(acc_we && clr_we))
        else $error("accumulate write-back collides with clearing pass");

    a_s1_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_acc |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("write-back without an accepted word");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_row < r_vs) && (r_vs != '0))
        else $error("row counter beyond vertical scale");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty cell result not marked last");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_READ) |=> !s_axis_tready)
        else $error("word accepted during read-out");

endmodule
